/* rtl/group_scaled_int8_dot_product_unit_defines.svh */
// Assertion macros used by the checker file of the group-scaled int8 dot product unit.
// Stand-alone header with no dependencies; included by gsdp_checker.sv, which holds the assertions.
`ifndef GROUP_SCALED_INT8_DOT_PRODUCT_UNIT_DEFINES_SVH
`define GROUP_SCALED_INT8_DOT_PRODUCT_UNIT_DEFINES_SVH

// Overlapping implication, disabled while reset is asserted.
`define GSDP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gsdp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gsdp assertion failed");

// Next-cycle implication that is also checked across reset.
`define GSDP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gsdp assertion failed");

`endif

/* rtl/gsdp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the group-scaled int8 dot product unit.
// No dependencies; used by every module of the block.
package gsdp_pkg;

    localparam int LANES       = 8;
    localparam int BYTE_W      = 8;
    localparam int PROD_W      = 2 * BYTE_W;
    localparam int SUM_W       = 24;
    localparam int SCALE_W     = 24;
    localparam int SPROD_W     = 2 * SCALE_W;
    localparam int FRAC_W      = 16;
    localparam int SCALE_Q_W   = SPROD_W - FRAC_W;
    localparam int MULT_FULL_W = SUM_W + SCALE_Q_W + 1;
    localparam int MULT_W      = SUM_W + SCALE_Q_W;
    localparam int ACC_W       = 48;
    localparam int ACCX_W      = MULT_W + 1;
    localparam int CFG_W       = 6;
    localparam int CNT_W       = 5;
    localparam int WORD_W      = 64;

    localparam logic [CFG_W-1:0] GROUP_MIN   = CFG_W'(1);
    localparam logic [CFG_W-1:0] GROUP_MAX   = CFG_W'(32);
    localparam logic [CFG_W-1:0] GROUP_RESET = CFG_W'(8);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  gsum_t;

    typedef struct packed {
        logic add;
        logic clear;
    } merge_ctl_t;

    function automatic logic [CFG_W-1:0] effective_group(input logic [CFG_W-1:0] g);
        logic [CFG_W-1:0] eff;
        if (g == '0) begin
            eff = GROUP_MIN;
        end else if (g > GROUP_MAX) begin
            eff = GROUP_MAX;
        end else begin
            eff = g;
        end
        return eff;
    endfunction

endpackage

/* rtl/gsdp_lane.sv */
`timescale 1ns / 1ps
// One multiply lane: registers the signed product of an int8 activation and an int8 weight.
// Depends on gsdp_pkg for the byte and product types.
module gsdp_lane (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [gsdp_pkg::BYTE_W-1:0]     act_byte,
    input  logic [gsdp_pkg::BYTE_W-1:0]     wt_byte,
    output gsdp_pkg::prod_t                 product
);

    gsdp_pkg::prod_t prod_reg;
    gsdp_pkg::prod_t prod_next;

    always_comb begin
        prod_next = $signed(act_byte) * $signed(wt_byte);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule

/* rtl/gsdp_merge.sv */
`timescale 1ns / 1ps
// Merging stage: adds the lane products of one request into the exact group sum.
// Depends on gsdp_pkg for the product, sum and control types.
module gsdp_merge (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  gsdp_pkg::merge_ctl_t    ctl,
    input  gsdp_pkg::prod_t         prods [gsdp_pkg::LANES],
    output gsdp_pkg::gsum_t         group_sum
);

    gsdp_pkg::gsum_t group_sum_reg;
    gsdp_pkg::gsum_t group_sum_next;
    gsdp_pkg::gsum_t lane_total;

    always_comb begin
        lane_total = '0;
        for (int i = 0; i < gsdp_pkg::LANES; i++) begin
            lane_total = lane_total + gsdp_pkg::SUM_W'(prods[i]);
        end
    end

    always_comb begin
        priority if (ctl.clear) begin
            group_sum_next = '0;
        end else if (ctl.add) begin
            group_sum_next = group_sum_reg + lane_total;
        end else begin
            group_sum_next = group_sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_sum_reg <= '0;
        end else begin
            group_sum_reg <= group_sum_next;
        end
    end

    assign group_sum = group_sum_reg;

endmodule

/* rtl/group_scaled_int8_dot_product_unit.sv */
`timescale 1ns / 1ps
// Group-scaled int8 dot product unit: top level with control, scaling and row accumulation.
// Depends on gsdp_pkg, gsdp_lane and gsdp_merge.
// Each request carries eight int8 activation/weight pairs that eight lanes multiply in
// parallel; the merging stage adds them into an exact group sum. After group_chunks
// requests (0 taken as 1, above 32 as 32) the group sum is multiplied by the truncated
// Q16.16 product of the two scales and added, with saturation to 48 bits, into the Q32.16
// row accumulator. The request flagged as row end yields one result holding the row value
// and a sticky clip flag. A request passes through lane multiply, group merge, scale
// multiply and accumulate, sequenced by the controller, which accepts the next request
// only after the previous one has left the accumulate stage; a row-end request takes
// longer only while an earlier result is still waiting on the result port.
// Writing group_chunks is allowed only while the unit is idle.
module group_scaled_int8_dot_product_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [gsdp_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [gsdp_pkg::WORD_W-1:0]          s_act_bytes,
    input  logic [gsdp_pkg::WORD_W-1:0]          s_wt_bytes,
    input  logic [gsdp_pkg::SCALE_W-1:0]         s_act_scale,
    input  logic [gsdp_pkg::SCALE_W-1:0]         s_wt_scale,
    input  logic                                 s_row_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [gsdp_pkg::ACC_W-1:0]    m_dot_value,
    output logic                                 m_saturated
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LANE  = 2'd1;
    localparam logic [1:0] ST_GROUP = 2'd2;
    localparam logic [1:0] ST_ACCUM = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [gsdp_pkg::CFG_W-1:0] group_chunks_reg;
    logic [gsdp_pkg::CNT_W-1:0] chunk_count_reg, chunk_count_next;
    logic close_reg, close_next;
    logic row_end_reg;
    logic [gsdp_pkg::SCALE_W-1:0] act_scale_reg, wt_scale_reg;
    logic [gsdp_pkg::SPROD_W-1:0] scale_prod_reg;
    logic signed [gsdp_pkg::MULT_W-1:0] mult_reg;
    logic signed [gsdp_pkg::MULT_FULL_W-1:0] mult_full;
    logic signed [gsdp_pkg::ACC_W-1:0] row_accum_reg, row_accum_next;
    logic clip_flag_reg, clip_flag_next;
    logic signed [gsdp_pkg::ACCX_W-1:0] acc_sum;
    logic signed [gsdp_pkg::ACC_W-1:0] acc_new;
    logic clip_new;
    logic m_valid_reg, m_valid_next;
    logic signed [gsdp_pkg::ACC_W-1:0] m_dot_value_reg, m_dot_value_next;
    logic m_saturated_reg, m_saturated_next;
    logic accept, out_free, emit;
    logic [gsdp_pkg::CFG_W-1:0] count_plus;
    gsdp_pkg::merge_ctl_t merge_ctl;
    gsdp_pkg::prod_t prods [gsdp_pkg::LANES];
    gsdp_pkg::gsum_t group_sum;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (state_reg == ST_ACCUM) && row_end_reg && out_free;

    for (genvar i = 0; i < gsdp_pkg::LANES; i++) begin : g_lane
        gsdp_lane u_lane (
            .aclk     (aclk),
            .en       (accept),
            .act_byte (s_act_bytes[i*gsdp_pkg::BYTE_W +: gsdp_pkg::BYTE_W]),
            .wt_byte  (s_wt_bytes[i*gsdp_pkg::BYTE_W +: gsdp_pkg::BYTE_W]),
            .product  (prods[i])
        );
    end

    assign merge_ctl.add   = (state_reg == ST_LANE);
    assign merge_ctl.clear = ((state_reg == ST_GROUP) && close_reg) || emit;

    gsdp_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (merge_ctl),
        .prods     (prods),
        .group_sum (group_sum)
    );

    always_comb begin
        count_plus = gsdp_pkg::CFG_W'(chunk_count_reg) + gsdp_pkg::CFG_W'(1);
        close_next = count_plus >= gsdp_pkg::effective_group(group_chunks_reg);
        if (emit) begin
            chunk_count_next = '0;
        end else if (accept) begin
            chunk_count_next = close_next ? '0 : count_plus[gsdp_pkg::CNT_W-1:0];
        end else begin
            chunk_count_next = chunk_count_reg;
        end
    end

    always_comb begin
        mult_full = group_sum * $signed({1'b0,
            scale_prod_reg[gsdp_pkg::SPROD_W-1:gsdp_pkg::FRAC_W]});
        acc_sum = gsdp_pkg::ACCX_W'(row_accum_reg) + gsdp_pkg::ACCX_W'(mult_reg);
        acc_new = row_accum_reg;
        clip_new = clip_flag_reg;
        if (close_reg) begin
            if (acc_sum[gsdp_pkg::ACCX_W-1:gsdp_pkg::ACC_W-1] == '0
                    || acc_sum[gsdp_pkg::ACCX_W-1:gsdp_pkg::ACC_W-1] == '1) begin
                acc_new = acc_sum[gsdp_pkg::ACC_W-1:0];
            end else if (acc_sum[gsdp_pkg::ACCX_W-1]) begin
                acc_new = gsdp_pkg::ACC_MIN;
                clip_new = 1'b1;
            end else begin
                acc_new = gsdp_pkg::ACC_MAX;
                clip_new = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        row_accum_next = row_accum_reg;
        clip_flag_next = clip_flag_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_dot_value_next = m_dot_value_reg;
        m_saturated_next = m_saturated_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LANE;
                end
            end
            ST_LANE: begin
                state_next = ST_GROUP;
            end
            ST_GROUP: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (!row_end_reg) begin
                    row_accum_next = acc_new;
                    clip_flag_next = clip_new;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    row_accum_next = '0;
                    clip_flag_next = 1'b0;
                    m_valid_next = 1'b1;
                    m_dot_value_next = acc_new;
                    m_saturated_next = clip_new;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            group_chunks_reg <= gsdp_pkg::GROUP_RESET;
            chunk_count_reg <= '0;
            row_accum_reg <= '0;
            clip_flag_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                group_chunks_reg <= cfg_wdata;
            end
            chunk_count_reg <= chunk_count_next;
            row_accum_reg <= row_accum_next;
            clip_flag_reg <= clip_flag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            close_reg <= close_next;
            row_end_reg <= s_row_end;
            act_scale_reg <= s_act_scale;
            wt_scale_reg <= s_wt_scale;
        end
        if (state_reg == ST_LANE) begin
            scale_prod_reg <= act_scale_reg * wt_scale_reg;
        end
        if (state_reg == ST_GROUP) begin
            mult_reg <= mult_full[gsdp_pkg::MULT_W-1:0];
        end
        m_dot_value_reg <= m_dot_value_next;
        m_saturated_reg <= m_saturated_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_dot_value = m_dot_value_reg;
    assign m_saturated = m_saturated_reg;

endmodule

/* rtl/gsdp_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the group-scaled int8 dot product unit, bound to the top level.
// Depends on gsdp_pkg and group_scaled_int8_dot_product_unit_defines.svh.
`include "group_scaled_int8_dot_product_unit_defines.svh"

module gsdp_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 cfg_we,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [gsdp_pkg::WORD_W-1:0]          s_act_bytes,
    input logic [gsdp_pkg::WORD_W-1:0]          s_wt_bytes,
    input logic [gsdp_pkg::SCALE_W-1:0]         s_act_scale,
    input logic [gsdp_pkg::SCALE_W-1:0]         s_wt_scale,
    input logic                                 s_row_end,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [gsdp_pkg::ACC_W-1:0]    m_dot_value,
    input logic                                 m_saturated
);

    logic [2*gsdp_pkg::WORD_W+2*gsdp_pkg::SCALE_W:0] s_payload;
    logic [gsdp_pkg::ACC_W:0]                        m_payload;

    assign s_payload = {s_act_bytes, s_wt_bytes, s_act_scale, s_wt_scale, s_row_end};
    assign m_payload = {m_dot_value, m_saturated};

    // A result that is not taken stays on the port unchanged.
    `GSDP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // A request that is not taken stays on the port unchanged.
    `GSDP_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_payload))

    // An accepted request keeps the input closed while it passes through the lane, group and accumulate states.
    `GSDP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready ##1 !s_ready ##1 !s_ready)

    // The group length is written only while the unit is idle and no request is offered.
    `GSDP_ASSERT_NOW(a_cfg_idle, aclk, aresetn, cfg_we, s_ready && !s_valid)

    // Reset leaves the unit idle with no pending result.
    `GSDP_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, s_ready && !m_valid)

endmodule

bind group_scaled_int8_dot_product_unit gsdp_checker u_gsdp_checker (.*);

/* tb/sv/tb_group_scaled_int8_dot_product_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for group_scaled_int8_dot_product_unit: directed and random rows,
// a cycle-free predictor of the row dot products and a result checker. Depends on gsdp_pkg.
module tb_group_scaled_int8_dot_product_unit;

    localparam int DRAIN_CYCLES = 20;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_ITEMS  = 130;

    typedef struct {
        logic [gsdp_pkg::WORD_W-1:0]  act;
        logic [gsdp_pkg::WORD_W-1:0]  wt;
        logic [gsdp_pkg::SCALE_W-1:0] act_scale;
        logic [gsdp_pkg::SCALE_W-1:0] wt_scale;
        logic                         row_end;
    } dot_req_t;

    typedef struct {
        logic signed [gsdp_pkg::ACC_W-1:0] dot;
        logic                              sat;
    } row_result_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [gsdp_pkg::CFG_W-1:0]           cfg_wdata = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [gsdp_pkg::WORD_W-1:0]          s_act_bytes = '0;
    logic [gsdp_pkg::WORD_W-1:0]          s_wt_bytes = '0;
    logic [gsdp_pkg::SCALE_W-1:0]         s_act_scale = '0;
    logic [gsdp_pkg::SCALE_W-1:0]         s_wt_scale = '0;
    logic                                 s_row_end = 1'b0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [gsdp_pkg::ACC_W-1:0]    m_dot_value;
    logic                                 m_saturated;

    dot_req_t    pending_reqs[$];
    row_result_t pending_rows[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatch_count = 0;

    logic [gsdp_pkg::CFG_W-1:0]        group_cfg = gsdp_pkg::GROUP_RESET;
    gsdp_pkg::gsum_t                   grp_sum = '0;
    logic [gsdp_pkg::CNT_W-1:0]        chunk_cnt = '0;
    logic signed [gsdp_pkg::ACC_W-1:0] row_acc = '0;
    logic                              clip = 1'b0;

    group_scaled_int8_dot_product_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_act_bytes (s_act_bytes),
        .s_wt_bytes  (s_wt_bytes),
        .s_act_scale (s_act_scale),
        .s_wt_scale  (s_wt_scale),
        .s_row_end   (s_row_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dot_value (m_dot_value),
        .m_saturated (m_saturated)
    );

    always #5 aclk = ~aclk;

    task automatic dot_accept(input logic [gsdp_pkg::WORD_W-1:0] act,
                              input logic [gsdp_pkg::WORD_W-1:0] wt,
                              input logic [gsdp_pkg::SCALE_W-1:0] a_sc,
                              input logic [gsdp_pkg::SCALE_W-1:0] w_sc,
                              input logic last);
        gsdp_pkg::prod_t              pair;
        logic [gsdp_pkg::SPROD_W-1:0] sc_full;
        int                           glen;
        longint signed                sum;
        row_result_t                  res;
        for (int l = 0; l < gsdp_pkg::LANES; l++) begin
            pair = $signed(act[gsdp_pkg::BYTE_W*l +: gsdp_pkg::BYTE_W])
                 * $signed(wt[gsdp_pkg::BYTE_W*l +: gsdp_pkg::BYTE_W]);
            grp_sum = grp_sum + pair;
        end
        glen = int'(gsdp_pkg::effective_group(group_cfg));
        if (int'(chunk_cnt) + 1 >= glen) begin
            sc_full = a_sc * w_sc;
            sum = longint'(row_acc) + longint'(grp_sum)
                * longint'(sc_full[gsdp_pkg::SPROD_W-1:gsdp_pkg::FRAC_W]);
            if (sum > longint'(gsdp_pkg::ACC_MAX)) begin
                sum = longint'(gsdp_pkg::ACC_MAX);
                clip = 1'b1;
            end
            if (sum < longint'(gsdp_pkg::ACC_MIN)) begin
                sum = longint'(gsdp_pkg::ACC_MIN);
                clip = 1'b1;
            end
            row_acc = gsdp_pkg::ACC_W'(sum);
            grp_sum = '0;
            chunk_cnt = '0;
        end else begin
            chunk_cnt = chunk_cnt + 1'b1;
        end
        if (last) begin
            res.dot = row_acc;
            res.sat = clip;
            pending_rows.insert(pending_rows.size(), res);
            grp_sum = '0;
            chunk_cnt = '0;
            row_acc = '0;
            clip = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        dot_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                dot_accept(s_act_bytes, s_wt_bytes, s_act_scale, s_wt_scale, s_row_end);
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    s_valid     <= 1'b1;
                    s_act_bytes <= nxt.act;
                    s_wt_bytes  <= nxt.wt;
                    s_act_scale <= nxt.act_scale;
                    s_wt_scale  <= nxt.wt_scale;
                    s_row_end   <= nxt.row_end;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        row_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_rows.size() == 0) begin
                    $error("unexpected result: dot_value %0d saturated %0b",
                           m_dot_value, m_saturated);
                    mismatch_count++;
                end else begin
                    want = pending_rows.pop_front();
                    if (m_dot_value !== want.dot) begin
                        $error("dot_value: expected %0d, actual %0d", want.dot, m_dot_value);
                        mismatch_count++;
                    end
                    if (m_saturated !== want.sat) begin
                        $error("saturated: expected %0b, actual %0b", want.sat, m_saturated);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [gsdp_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(9))
            0: begin
                return {gsdp_pkg::LANES{8'h80}};
            end
            1: begin
                return {gsdp_pkg::LANES{8'h7F}};
            end
            default: begin
                return {$urandom, $urandom};
            end
        endcase
    endfunction

    function automatic logic [gsdp_pkg::SCALE_W-1:0] rand_scale();
        case ($urandom_range(7))
            0: begin
                return {gsdp_pkg::SCALE_W{1'b1}};
            end
            1: begin
                return '0;
            end
            default: begin
                return gsdp_pkg::SCALE_W'($urandom_range(0,
                    (1 << $urandom_range(1, gsdp_pkg::SCALE_W)) - 1));
            end
        endcase
    endfunction

    task automatic push_req(input logic [gsdp_pkg::WORD_W-1:0] act,
                            input logic [gsdp_pkg::WORD_W-1:0] wt,
                            input logic [gsdp_pkg::SCALE_W-1:0] a_sc,
                            input logic [gsdp_pkg::SCALE_W-1:0] w_sc,
                            input logic last);
        dot_req_t r;
        r.act       = act;
        r.wt        = wt;
        r.act_scale = a_sc;
        r.wt_scale  = w_sc;
        r.row_end   = last;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || pending_rows.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_group(input logic [gsdp_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        group_cfg = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic fill_rows(input int budget, input int glen);
        int made;
        int len;
        int kind;
        made = 0;
        while (made < budget) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                len = glen * $urandom_range(1, (glen > 8) ? 2 : 4);
            end else if (kind < 92) begin
                len = glen * $urandom_range(0, 2) + $urandom_range(1, glen);
            end else begin
                len = $urandom_range(1, 40);
            end
            for (int k = 0; k < len; k++) begin
                push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), k == len - 1);
            end
            made += len;
        end
        if ($urandom_range(1) == 1) begin
            len = $urandom_range(1, glen);
            for (int k = 0; k < len; k++) begin
                push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b0);
            end
        end
    endtask

    initial begin
        logic [gsdp_pkg::CFG_W-1:0] phase_cfg [RAND_PHASES];
        int                         glen;
        int                         send_pct [4];
        int                         recv_pct [4];
        phase_cfg = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd2, 6'd40, 6'd8};
        phase_cfg[4] = gsdp_pkg::CFG_W'($urandom_range(2, 31));
        phase_cfg[5] = gsdp_pkg::CFG_W'($urandom_range(33, 63));
        send_pct = '{0, 61, 0, 7};
        recv_pct = '{0, 0, 61, 7};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        write_group(6'd1);
        push_req({gsdp_pkg::LANES{8'h7F}}, {gsdp_pkg::LANES{8'h7F}},
                 24'h010000, 24'h010000, 1'b1);
        push_req({gsdp_pkg::LANES{8'h80}}, {gsdp_pkg::LANES{8'h80}},
                 {gsdp_pkg::SCALE_W{1'b1}}, {gsdp_pkg::SCALE_W{1'b1}}, 1'b1);
        push_req({gsdp_pkg::LANES{8'h80}}, {gsdp_pkg::LANES{8'h7F}},
                 {gsdp_pkg::SCALE_W{1'b1}}, {gsdp_pkg::SCALE_W{1'b1}}, 1'b1);
        push_req('0, '0, '0, '0, 1'b1);
        push_req(rand_word(), rand_word(), '0, '0, 1'b1);
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b0);
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b1);
        wait_idle();

        write_group(6'd3);
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b0);
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b1);
        for (int k = 0; k < 4; k++) begin
            push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), k == 3);
        end
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b0);
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b0);
        wait_idle();

        // Lowering the group length in the middle of a group closes it on the next request.
        write_group(6'd1);
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b1);
        wait_idle();

        write_group(6'd0);
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b0);
        push_req(rand_word(), rand_word(), rand_scale(), rand_scale(), 1'b1);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            send_idle_pct  = send_pct[p % 4];
            recv_stall_pct = recv_pct[p % 4];
            write_group(phase_cfg[p]);
            glen = int'(gsdp_pkg::effective_group(phase_cfg[p]));
            fill_rows(PHASE_ITEMS, glen);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("tb_group_scaled_int8_dot_product_unit: PASS");
        end else begin
            $display("tb_group_scaled_int8_dot_product_unit: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_group_scaled_int8_dot_product_unit: FAIL");
        $finish;
    end

endmodule
